FILE: rtl/core/spq_pkg.sv
// Shared types and codes for the priority ready queue.
// No dependencies; imported by spq_cell, stable_priority_ready_queue and the testbench.
`default_nettype none

package spq_pkg;

    localparam int ID_W            = 16;
    localparam int PRIO_W          = 4;
    localparam int STATUS_W        = 2;
    localparam int OCC_W           = 5;
    localparam int QUEUE_DEPTH_DEF = 16;

    // Command codes.
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_ENQUEUED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DEQUEUED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    // One stored queue entry.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_spq_entry;

    // Control broadcast to every cell in a cycle.
    typedef struct packed {
        logic       enq;
        logic       deq;
        t_spq_entry new_entry;
    } t_spq_ctl;

endpackage

`default_nettype wire

FILE: rtl/core/spq_cell.sv
// One slot of the sorted shift chain: holds an entry and picks its next value.
// Depends on spq_pkg for the entry and control structs.
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_spq_ctl   i_ctl,
    input  wire logic       i_occupied,
    input  wire logic       i_left_keep,
    input  wire t_spq_entry i_left,
    input  wire t_spq_entry i_right,
    output t_spq_entry      o_entry,
    output logic            o_keep
);

    t_spq_entry r_entry;
    t_spq_entry n_entry;

    // The entry stays in place on an enqueue when it ranks at or above the new one.
    assign o_keep  = i_occupied && (r_entry.prio >= i_ctl.new_entry.prio);
    assign o_entry = r_entry;

    // Next value: insert the new item at the boundary, shift right behind it,
    // or shift left on a dequeue.
    always_comb begin
        n_entry = r_entry;
        priority if (i_ctl.enq) begin
            if (!o_keep) begin
                if (i_left_keep) begin
                    n_entry = i_ctl.new_entry;
                end else begin
                    n_entry = i_left;
                end
            end
        end else if (i_ctl.deq) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

FILE: rtl/core/stable_priority_ready_queue.sv
// A result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle while results are taken as they appear.
// A waiting result holds off the input; a new item enters in the cycle it is taken.
// Reset (synchronous, active low) empties the queue and clears the result valid;
// cell contents are not reset and are only read below the entry count.
`default_nettype none

module stable_priority_ready_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic                i_cmd,
    input  wire logic [ID_W-1:0]     i_proc_id,
    input  wire logic [PRIO_W-1:0]   i_priority_req,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [STATUS_W-1:0]      o_status,
    output logic [ID_W-1:0]          o_out_id,
    output logic [PRIO_W-1:0]        o_out_priority,
    output logic [OCC_W-1:0]         o_occupancy
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;
    logic [ID_W-1:0]     r_out_id;
    logic [ID_W-1:0]     n_out_id;
    logic [PRIO_W-1:0]   r_out_prio;
    logic [PRIO_W-1:0]   n_out_prio;

    logic     w_accept;
    logic     w_full;
    logic     w_empty;
    t_spq_ctl w_ctl;

    t_spq_entry w_entry [QUEUE_DEPTH];
    logic       w_keep  [QUEUE_DEPTH];

    // Handshake: take an item whenever the result register is free or draining.
    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_full   = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty  = (r_count == '0);

    // Control broadcast to the chain.
    assign w_ctl.enq            = w_accept && (i_cmd == CMD_ENQ) && !w_full;
    assign w_ctl.deq            = w_accept && (i_cmd == CMD_DEQ) && !w_empty;
    assign w_ctl.new_entry.id   = i_proc_id;
    assign w_ctl.new_entry.prio = i_priority_req;

    // The chain of cells, head at index zero.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_spq_entry w_left;
        t_spq_entry w_right;
        logic       w_left_keep;

        if (g == 0) begin : g_head
            assign w_left      = w_ctl.new_entry;
            assign w_left_keep = 1'b1;
        end else begin : g_body
            assign w_left      = w_entry[g-1];
            assign w_left_keep = w_keep[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_right = w_entry[g];
        end else begin : g_mid
            assign w_right = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occupied  (CNT_W'(g) < r_count),
            .i_left_keep (w_left_keep),
            .i_left      (w_left),
            .i_right     (w_right),
            .o_entry     (w_entry[g]),
            .o_keep      (w_keep[g])
        );
    end

    // Result and count for the accepted item.
    always_comb begin
        n_count    = r_count;
        n_out_id   = '0;
        n_out_prio = '0;
        n_status   = ST_ENQUEUED;
        unique case (i_cmd)
            CMD_ENQ: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_DEQ: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_status   = ST_DEQUEUED;
                    n_out_id   = w_entry[0].id;
                    n_out_prio = w_entry[0].prio;
                    n_count    = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = ST_ENQUEUED;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status   <= n_status;
            r_out_id   <= n_out_id;
            r_out_prio <= n_out_prio;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_out_id       = r_out_id;
    assign o_out_priority = r_out_prio;
    assign o_occupancy    = OCC_W'(r_count);

    // The count never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above capacity");

    // An accepted enqueue grows the queue by one.
    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.enq |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("enqueue did not grow the count");

    // A dequeue on an empty queue reports empty with a zero id and zero occupancy.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd == CMD_DEQ) && w_empty) |=>
        (o_valid && (o_status == ST_EMPTY) && (o_out_id == '0) && (o_occupancy == '0)))
        else $error("empty dequeue result wrong");

    // The two head entries stay in priority order.
    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count > CNT_W'(1)) |-> (w_entry[0].prio >= w_entry[1].prio))
        else $error("head entries out of order");

endmodule

`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for the stable priority ready queue.
// Depends on spq_pkg and stable_priority_ready_queue; a directed table then random traffic
// with random idling on both handshakes; results checked against a behavioral model or typed rows.
`default_nettype none

module tb;
    import spq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_DIRECTED = 22;
    localparam int NUM_RANDOM   = 1200;

    // One result as the block reports it.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic [PRIO_W-1:0]   prio;
        logic [OCC_W-1:0]    occ;
    } t_outcome;

    // One row of the directed table; typed marks a result written in by hand.
    typedef struct packed {
        logic              cmd;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic              typed;
        t_outcome          result;
    } t_row;

    localparam t_outcome NO_OUTCOME = '{ST_ENQUEUED, 16'h0000, 4'd0, 5'd0};

    // Empty dequeue, a full fill with extreme ids and priorities, a rejected
    // enqueue, then a few dequeues to show the ordering.
    localparam t_row DIRECTED [0:NUM_DIRECTED-1] = '{
        '{CMD_DEQ, 16'h0000, 4'd0,  1'b1, '{ST_EMPTY,    16'h0000, 4'd0, 5'd0}},
        '{CMD_ENQ, 16'h0000, 4'd1,  1'b1, '{ST_ENQUEUED, 16'h0000, 4'd0, 5'd1}},
        '{CMD_ENQ, 16'hFFFF, 4'd10, 1'b0, NO_OUTCOME},
        '{CMD_ENQ, 16'h1234, 4'd10, 1'b0, NO_OUTCOME},
        '{CMD_ENQ, 16'hAAAA, 4'd0,  1'b0, NO_OUTCOME},
        '{CMD_ENQ, 16'h5555, 4'd15, 1'b0, NO_OUTCOME},
        '{CMD_ENQ, 16'hFFFF, 4'd5,  1'b0, NO_OUTCOME},
        '{CMD_ENQ, 16'h0001, 4'd5,  1'b0, NO_OUTCOME},
        '{CMD_ENQ, 16'h8000, 4'd1,  1'b0, NO_OUTCOME},
        '{CMD_ENQ, 16'h7FFF, 4'd10, 1'b0, NO_OUTCOME},
        '{CMD_ENQ, 16'h00FF, 4'd3,  1'b0, NO_OUTCOME},
        '{CMD_ENQ, 16'hFF00, 4'd7,  1'b0, NO_OUTCOME},
        '{CMD_ENQ, 16'h0F0F, 4'd2,  1'b0, NO_OUTCOME},
        '{CMD_ENQ, 16'hF0F0, 4'd9,  1'b0, NO_OUTCOME},
        '{CMD_ENQ, 16'h3C3C, 4'd5,  1'b0, NO_OUTCOME},
        '{CMD_ENQ, 16'hC3C3, 4'd11, 1'b0, NO_OUTCOME},
        '{CMD_ENQ, 16'h0002, 4'd1,  1'b0, NO_OUTCOME},
        '{CMD_ENQ, 16'hBEEF, 4'd10, 1'b1, '{ST_FULL,     16'h0000, 4'd0, 5'd16}},
        '{CMD_DEQ, 16'hFFFF, 4'd15, 1'b0, NO_OUTCOME},
        '{CMD_DEQ, 16'h0000, 4'd0,  1'b0, NO_OUTCOME},
        '{CMD_DEQ, 16'hFFFF, 4'd15, 1'b0, NO_OUTCOME},
        '{CMD_DEQ, 16'h0000, 4'd0,  1'b0, NO_OUTCOME}
    };

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_valid        = 1'b0;
    logic              i_cmd          = CMD_ENQ;
    logic [ID_W-1:0]   i_proc_id      = '0;
    logic [PRIO_W-1:0] i_priority_req = '0;
    logic              i_ready        = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [ID_W-1:0]     o_out_id;
    logic [PRIO_W-1:0]   o_out_priority;
    logic [OCC_W-1:0]    o_occupancy;

    // Model of the queue contents, head at index 0, and results still owed.
    t_spq_entry model_entries[$];
    t_outcome   pending_outcomes[$];
    int         fail_count = 0;
    bit         burst      = 1'b0;

    stable_priority_ready_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH_DEF)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_proc_id     (i_proc_id),
        .i_priority_req(i_priority_req),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_out_id      (o_out_id),
        .o_out_priority(o_out_priority),
        .o_occupancy   (o_occupancy)
    );

    // Clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Apply one item to the queue model and return the result it causes.
    function automatic t_outcome schedule_item(input logic cmd, input logic [ID_W-1:0] id,
                                               input logic [PRIO_W-1:0] prio);
        t_outcome   res;
        t_spq_entry ent;
        int         pos;
        res = NO_OUTCOME;
        if (cmd == CMD_ENQ) begin
            if (model_entries.size() >= QUEUE_DEPTH_DEF) begin
                res.status = ST_FULL;
            end else begin
                // New entry goes behind every entry of equal or higher priority.
                pos = 0;
                while (pos < model_entries.size() && model_entries[pos].prio >= prio)
                    pos++;
                ent.id   = id;
                ent.prio = prio;
                model_entries.insert(pos, ent);
                res.status = ST_ENQUEUED;
            end
        end else begin
            if (model_entries.size() == 0) begin
                res.status = ST_EMPTY;
            end else begin
                ent        = model_entries.pop_front();
                res.status = ST_DEQUEUED;
                res.id     = ent.id;
                res.prio   = ent.prio;
            end
        end
        res.occ = OCC_W'(model_entries.size());
        return res;
    endfunction

    // Offer one item after a random gap and record its expected result once accepted.
    task automatic send_item(input logic cmd, input logic [ID_W-1:0] id,
                             input logic [PRIO_W-1:0] prio, input logic typed,
                             input t_outcome typed_result);
        int       gap;
        t_outcome predicted;
        gap = burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cmd          <= cmd;
        i_proc_id      <= id;
        i_priority_req <= prio;
        do @(posedge i_clk); while (!o_ready);
        predicted = schedule_item(cmd, id, prio);
        pending_outcomes.push_back(typed ? typed_result : predicted);
    endtask

    // Field-by-field comparison of one result.
    task automatic compare_outcome(input t_outcome want, input t_outcome got);
        if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            fail_count++;
        end
        if (got.id !== want.id) begin
            $error("out_id expected %0h actual %0h", want.id, got.id);
            fail_count++;
        end
        if (got.prio !== want.prio) begin
            $error("out_priority expected %0d actual %0d", want.prio, got.prio);
            fail_count++;
        end
        if (got.occ !== want.occ) begin
            $error("occupancy expected %0d actual %0d", want.occ, got.occ);
            fail_count++;
        end
    endtask

    // Stimulus: reset, directed table, random traffic, then drain and report.
    initial begin
        int       phase;
        int       phase_left;
        int       enq_pct;
        logic     cmd;
        logic [PRIO_W-1:0] prio;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < NUM_DIRECTED; r++) begin
            send_item(DIRECTED[r].cmd, DIRECTED[r].id, DIRECTED[r].prio,
                      DIRECTED[r].typed, DIRECTED[r].result);
        end
        i_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);

        // Random part alternates fill, drain and mixed phases so the queue
        // keeps hitting both the full and the empty boundary.
        phase      = 0;
        phase_left = 0;
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (phase_left == 0) begin
                phase      = $urandom_range(0, 2);
                phase_left = $urandom_range(10, 60);
            end
            phase_left--;
            if ($urandom_range(0, 49) == 0)
                burst = ~burst;
            enq_pct = (phase == 0) ? 80 : (phase == 1) ? 20 : 50;
            cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
            // Mostly legal priorities, sometimes a narrow range for many ties,
            // occasionally any 4-bit value.
            case ($urandom_range(0, 7))
                0: begin
                    prio = PRIO_W'($urandom_range(0, 15));
                end
                1, 2: begin
                    prio = PRIO_W'($urandom_range(4, 5));
                end
                default: begin
                    prio = PRIO_W'($urandom_range(1, 10));
                end
            endcase
            send_item(cmd, ID_W'($urandom), prio, 1'b0, NO_OUTCOME);
            // Halfway through, let the queue's results all drain before going on.
            if (n == NUM_RANDOM / 2) begin
                i_valid <= 1'b0;
                while (pending_outcomes.size() != 0) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;

        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Result side: random stall before each result, then take and check it.
    initial begin
        int       stall;
        t_outcome got;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = burst ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            got = '{o_status, o_out_id, o_out_priority, o_occupancy};
            if (pending_outcomes.size() == 0) begin
                $error("result arrived with no item outstanding: status %0d", o_status);
                fail_count++;
            end else begin
                compare_outcome(pending_outcomes.pop_front(), got);
            end
        end
    end

    // Watchdog for a stalled handshake.
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
